@@ design/led_pkg.sv @@
// Package for the layered exponential density block.
// Holds the default table depth, fixed-point constants and opcodes; depends on nothing.
`default_nettype none

package led_pkg;

   localparam int MAX_LAYERS_DEFAULT = 16;
   localparam int KM_TO_CM = 100000;
   localparam int G_CM3_TO_KG_M3 = 1000;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [4:0] TAYLOR_TERMS = 5'd24;
   localparam logic [63:0] EXP_TOP = 64'd40 << 32;
   localparam logic [63:0] EXP_BOTTOM_MAG = 64'd64 << 32;
   localparam logic [63:0] TERM_ONE = 64'd1 << 60;
   localparam logic [63:0] DENSITY_MAX = 64'h0000_0000_FFFF_FFFF;
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

@@ design/layered_exponential_density.sv @@
// Top level of the layered exponential density block: layer table, search,
// shared divider, shared 32x32 multiplier and their sequencer. Uses led_pkg.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------
//  request  | start, busy, req_*                      | taken on start & !busy
//  result   | rsp_valid, rsp_density, rsp_saturated,  | one-cycle strobe,
//           | rsp_layer_used                          | no back-pressure
//  control  | csr_wr_en, csr_wr_data                  | written when csr_wr_en
//
// A layer write leaves busy low. A query holds busy high until its result is
// ready; the result strobe comes in the cycle busy drops. The shared divider
// yields one quotient bit per cycle and serves each of the two scale-height
// divisions and each of the 24 terms. Reset sets the active layer count to 1
// and returns the sequencer to idle; the layer table holds whatever was
// written. Results cannot be stalled.
`default_nettype none

module layered_exponential_density #(
   parameter int MAX_LAYERS = led_pkg::MAX_LAYERS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_opcode,
   input  wire logic [3:0]         req_layer_slot,
   input  wire logic signed [23:0] req_layer_top,
   input  wire logic [26:0]        req_layer_mass,
   input  wire logic [20:0]        req_layer_scale,
   input  wire logic signed [23:0] req_altitude,
   output logic                    rsp_valid,
   output logic [31:0]             rsp_density,
   output logic                    rsp_saturated,
   output logic [3:0]              rsp_layer_used,
   input  wire logic               csr_wr_en,
   input  wire logic [4:0]         csr_wr_data
);

   localparam int AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RDW  = 4'd1;
   localparam logic [3:0] S_CMP  = 4'd2;
   localparam logic [3:0] S_KCHK = 4'd3;
   localparam logic [3:0] S_ECHK = 4'd4;
   localparam logic [3:0] S_NFIX = 4'd5;
   localparam logic [3:0] S_TDIV = 4'd6;
   localparam logic [3:0] S_TACC = 4'd7;
   localparam logic [3:0] S_FIN  = 4'd8;
   localparam logic [3:0] S_DIV  = 4'd9;
   localparam logic [3:0] S_MLO  = 4'd10;
   localparam logic [3:0] S_MHI  = 4'd11;
   localparam logic [3:0] S_MSUM = 4'd12;
   localparam logic [3:0] S_NDIV = 4'd13;

   logic signed [23:0] top_mem [MAX_LAYERS];
   logic [26:0]        mass_mem [MAX_LAYERS];
   logic [20:0]        scale_mem [MAX_LAYERS];

   logic signed [23:0] top_rd_ff;
   logic [26:0]        mass_rd_ff;
   logic [20:0]        scale_rd_ff;

   logic [3:0]  state_ff, state_in;
   logic [3:0]  ret_ff, ret_in;
   logic [4:0]  active_ff;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] last_ff, last_in;
   logic signed [23:0] h_ff, h_in;
   logic [20:0] c_ff, c_in;
   logic [63:0] k_ff, k_in;
   logic        eneg_ff, eneg_in;
   logic signed [7:0] n_ff, n_in;
   logic [6:0]  nq_ff, nq_in;
   logic [31:0] r_ff, r_in;
   logic [63:0] sum_ff, sum_in;
   logic [4:0]  kk_ff, kk_in;

   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [5:0]  dcnt_ff, dcnt_in;

   logic [63:0] ma_ff, ma_in;
   logic [31:0] mb_ff, mb_in;
   logic [63:0] plo_ff, plo_in;
   logic [63:0] phi_ff, phi_in;
   logic [63:0] mres_ff, mres_in;
   logic [31:0] mul_x;
   logic [63:0] prod;

   logic        valid_ff, valid_in;
   logic [31:0] dens_ff, dens_in;
   logic        sat_ff, sat_in;
   logic [3:0]  used_ff, used_in;

   logic        wr_go;
   logic [6:0]  count_eff;

   assign busy = (state_ff != S_IDLE);
   assign wr_go = start && !busy && (req_opcode == led_pkg::OP_WRITE) &&
                  ({3'b000, req_layer_slot} < 7'(MAX_LAYERS));

   assign mul_x = (state_ff == S_MHI) ? ma_ff[63:32] : ma_ff[31:0];
   assign prod = mul_x * mb_ff;

   always_comb begin
      if (active_ff == 5'd0) begin
         count_eff = 7'd1;
      end else if ({2'b00, active_ff} > 7'(MAX_LAYERS)) begin
         count_eff = 7'(MAX_LAYERS);
      end else begin
         count_eff = {2'b00, active_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_go) begin
         top_mem[AW'(req_layer_slot)] <= req_layer_top;
         mass_mem[AW'(req_layer_slot)] <= req_layer_mass;
         scale_mem[AW'(req_layer_slot)] <= req_layer_scale;
      end
      top_rd_ff <= top_mem[idx_ff];
      mass_rd_ff <= mass_mem[idx_ff];
      scale_rd_ff <= scale_mem[idx_ff];
   end

   always_comb begin
      logic [32:0] rsh;
      logic [23:0] habs;
      logic [63:0] emag;
      logic [63:0] m;
      logic [63:0] mr;
      logic [63:0] lsh;
      logic [6:0]  shu;
      logic signed [8:0] shd_s;
      logic [7:0]  shd;
      logic [40:0] hm;
      logic [36:0] bm;
      logic [20:0] c_eff;

      state_in = state_ff;
      ret_in = ret_ff;
      idx_in = idx_ff;
      last_in = last_ff;
      h_in = h_ff;
      c_in = c_ff;
      k_in = k_ff;
      eneg_in = eneg_ff;
      n_in = n_ff;
      nq_in = nq_ff;
      r_in = r_ff;
      sum_in = sum_ff;
      kk_in = kk_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      dcnt_in = dcnt_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      plo_in = plo_ff;
      phi_in = phi_ff;
      mres_in = mres_ff;
      valid_in = 1'b0;
      dens_in = dens_ff;
      sat_in = sat_ff;
      used_in = used_ff;

      rsh = {rem_ff, quo_ff[63]};
      habs = h_ff[23] ? (~h_ff + 24'd1) : h_ff;
      hm = 41'(habs) * 41'(led_pkg::KM_TO_CM);
      bm = 37'(mass_rd_ff) * 37'(led_pkg::G_CM3_TO_KG_M3);
      c_eff = (scale_rd_ff == 21'd0) ? 21'd1 : scale_rd_ff;
      emag = quo_ff + 64'((h_ff > 24'sd0) && (rem_ff != 32'd0));
      lsh = 64'(led_pkg::LN2_Q32) << dcnt_ff[2:0];
      m = mres_ff;
      mr = 64'd0;
      shu = 7'(n_ff - 8'sd1);
      shd_s = 9'sd1 - 9'(n_ff);
      shd = shd_s[7:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start && (req_opcode == led_pkg::OP_QUERY)) begin
               h_in = req_altitude;
               idx_in = '0;
               last_in = AW'(count_eff - 7'd1);
               state_in = S_RDW;
            end
         end
         S_RDW: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if ((h_ff < top_rd_ff) || (idx_ff == last_ff)) begin
               used_in = 4'(idx_ff);
               c_in = c_eff;
               quo_in = {11'd0, bm, 16'd0};
               rem_in = '0;
               dsr_in = 32'(c_eff);
               dcnt_in = '0;
               ret_in = S_KCHK;
               state_in = S_DIV;
            end else begin
               idx_in = idx_ff + AW'(1);
               state_in = S_RDW;
            end
         end
         S_DIV: begin
            if (rsh >= {1'b0, dsr_ff}) begin
               rem_in = 32'(rsh - {1'b0, dsr_ff});
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rsh[31:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'd63) begin
               state_in = ret_ff;
            end
         end
         S_KCHK: begin
            k_in = quo_ff;
            if (quo_ff == 64'd0) begin
               dens_in = '0;
               sat_in = 1'b0;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               quo_in = {7'd0, hm, 16'd0};
               rem_in = '0;
               dsr_in = 32'(c_ff);
               dcnt_in = '0;
               ret_in = S_ECHK;
               state_in = S_DIV;
            end
         end
         S_ECHK: begin
            eneg_in = (h_ff > 24'sd0);
            if (!(h_ff > 24'sd0) && (emag > led_pkg::EXP_TOP)) begin
               dens_in = 32'hFFFF_FFFF;
               sat_in = 1'b1;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else if ((h_ff > 24'sd0) && (emag > led_pkg::EXP_BOTTOM_MAG)) begin
               dens_in = '0;
               sat_in = 1'b0;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               quo_in = emag;
               nq_in = '0;
               dcnt_in = 6'd6;
               state_in = S_NDIV;
            end
         end
         S_NDIV: begin
            if (quo_ff >= lsh) begin
               quo_in = quo_ff - lsh;
               nq_in = {nq_ff[5:0], 1'b1};
            end else begin
               nq_in = {nq_ff[5:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 6'd1;
            if (dcnt_ff == 6'd0) begin
               state_in = S_NFIX;
            end
         end
         S_NFIX: begin
            if (!eneg_ff) begin
               n_in = {1'b0, nq_ff};
               r_in = quo_ff[31:0];
            end else if (quo_ff[31:0] != 32'd0) begin
               n_in = 8'd0 - ({1'b0, nq_ff} + 8'd1);
               r_in = led_pkg::LN2_Q32 - quo_ff[31:0];
            end else begin
               n_in = 8'd0 - {1'b0, nq_ff};
               r_in = '0;
            end
            sum_in = led_pkg::TERM_ONE;
            kk_in = 5'd1;
            ma_in = led_pkg::TERM_ONE;
            mb_in = r_in;
            ret_in = S_TDIV;
            state_in = S_MLO;
         end
         S_MLO: begin
            plo_in = prod;
            state_in = S_MHI;
         end
         S_MHI: begin
            phi_in = prod;
            state_in = S_MSUM;
         end
         S_MSUM: begin
            mres_in = phi_ff + (plo_ff >> 32);
            state_in = ret_ff;
         end
         S_TDIV: begin
            quo_in = mres_ff;
            rem_in = '0;
            dsr_in = 32'(kk_ff);
            dcnt_in = '0;
            ret_in = S_TACC;
            state_in = S_DIV;
         end
         S_TACC: begin
            sum_in = sum_ff + quo_ff;
            if (kk_ff == led_pkg::TAYLOR_TERMS) begin
               ma_in = k_ff;
               mb_in = 32'(sum_in >> 29);
               ret_in = S_FIN;
            end else begin
               kk_in = kk_ff + 5'd1;
               ma_in = quo_ff;
               mb_in = r_ff;
               ret_in = S_TDIV;
            end
            state_in = S_MLO;
         end
         S_FIN: begin
            sat_in = 1'b0;
            dens_in = '0;
            if (m == 64'd0) begin
               dens_in = '0;
            end else if (n_ff >= 8'sd1) begin
               if (shu >= 7'd32) begin
                  sat_in = 1'b1;
                  dens_in = 32'hFFFF_FFFF;
               end else if (m > (led_pkg::DENSITY_MAX >> shu[4:0])) begin
                  sat_in = 1'b1;
                  dens_in = 32'hFFFF_FFFF;
               end else begin
                  dens_in = 32'(m << shu[4:0]);
               end
            end else if (shd >= 8'd64) begin
               dens_in = '0;
            end else begin
               mr = m >> shd[5:0];
               if (mr > led_pkg::DENSITY_MAX) begin
                  sat_in = 1'b1;
                  dens_in = 32'hFFFF_FFFF;
               end else begin
                  dens_in = mr[31:0];
               end
            end
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         active_ff <= 5'd1;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;
      idx_ff <= idx_in;
      last_ff <= last_in;
      h_ff <= h_in;
      c_ff <= c_in;
      k_ff <= k_in;
      eneg_ff <= eneg_in;
      n_ff <= n_in;
      nq_ff <= nq_in;
      r_ff <= r_in;
      sum_ff <= sum_in;
      kk_ff <= kk_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      dcnt_ff <= dcnt_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      mres_ff <= mres_in;
      dens_ff <= dens_in;
      sat_ff <= sat_in;
      used_ff <= used_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_density = dens_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_layer_used = used_ff;

endmodule

`default_nettype wire

@@ tb/tb_layered_exponential_density.sv @@
// Self-checking testbench for layered_exponential_density: drives layer writes
// and density queries, predicts each result in fixed point and compares it.
// Depends on led_pkg and the layered_exponential_density RTL.
`default_nettype none

module tb_layered_exponential_density;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int    LAYERS     = led_pkg::MAX_LAYERS_DEFAULT;
   localparam int    STALL_MAX  = 20000;
   localparam longint LN2       = 64'd2977044472;
   localparam longint TOP_LIM   = 64'd40 << 32;
   localparam longint BOTTOM_LIM = -(64'd64 << 32);

   typedef enum logic {
      OP_WRITE = led_pkg::OP_WRITE,
      OP_QUERY = led_pkg::OP_QUERY
   } op_type;

   typedef struct {
      op_type             op;
      logic [3:0]         slot;
      logic signed [23:0] top;
      logic [26:0]        mass;
      logic [20:0]        scale;
      logic signed [23:0] alt;
   } request_type;

   typedef struct {
      logic [31:0] density;
      logic        saturated;
      logic [3:0]  layer_used;
   } density_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_opcode;
   logic [3:0]         req_layer_slot;
   logic signed [23:0] req_layer_top;
   logic [26:0]        req_layer_mass;
   logic [20:0]        req_layer_scale;
   logic signed [23:0] req_altitude;
   logic               rsp_valid;
   logic [31:0]        rsp_density;
   logic               rsp_saturated;
   logic [3:0]         rsp_layer_used;
   logic               csr_wr_en;
   logic [4:0]         csr_wr_data;

   request_type pending_reqs[$];
   density_type density_exp[$];
   request_type cur_req;
   int       idle_pct;
   int       fails;
   int       quiet_cycles;

   longint      top_tbl[LAYERS];
   logic [63:0] mass_tbl[LAYERS];
   logic [63:0] scale_tbl[LAYERS];
   logic [4:0]  layer_count;

   layered_exponential_density u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_layer_slot (req_layer_slot),
      .req_layer_top  (req_layer_top),
      .req_layer_mass (req_layer_mass),
      .req_layer_scale(req_layer_scale),
      .req_altitude   (req_altitude),
      .rsp_valid      (rsp_valid),
      .rsp_density    (rsp_density),
      .rsp_saturated  (rsp_saturated),
      .rsp_layer_used (rsp_layer_used),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic void queue_request(input request_type r);
      pending_reqs = {pending_reqs, r};
   endfunction

   function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[95:32];
   endfunction

   function automatic density_type calc_density(input longint h, input logic [63:0] b,
                                                input logic [63:0] c_in);
      density_type res;
      logic [63:0] c, k, mag, frac, term, sum, m;
      longint      e, n, sh;
      res = '{density: 32'd0, saturated: 1'b0, layer_used: 4'd0};
      c = (c_in == 0) ? 64'd1 : c_in;
      k = ((b * 64'd1000) << 16) / c;
      if (k == 0) return res;
      mag = 64'(h < 0 ? -h : h) * 64'd100000;
      mag = mag << 16;
      if (h > 0) e = -longint'((mag + c - 1) / c);
      else e = longint'(mag / c);
      if (e > TOP_LIM) begin
         res.density = '1;
         res.saturated = 1'b1;
         return res;
      end
      if (e < BOTTOM_LIM) return res;
      if (e >= 0) n = e / LN2;
      else n = -((-e + LN2 - 1) / LN2);
      frac = 64'(e - n * LN2);
      term = 64'd1 << 60;
      sum = term;
      for (int i = 1; i <= 24; i++) begin
         term = mul_q32(term, frac) / 64'(i);
         sum += term;
      end
      m = mul_q32(k, sum >> 29);
      if (m == 0) return res;
      if (n - 1 >= 0) begin
         sh = n - 1;
         if (sh >= 32 || m > (64'hFFFF_FFFF >> sh)) begin
            res.density = '1;
            res.saturated = 1'b1;
         end else begin
            res.density = 32'(m << sh);
         end
      end else begin
         sh = 1 - n;
         if (sh < 64) begin
            m = m >> sh;
            if (m > 64'hFFFF_FFFF) begin
               res.density = '1;
               res.saturated = 1'b1;
            end else begin
               res.density = 32'(m);
            end
         end
      end
      return res;
   endfunction

   function automatic void apply_request(input request_type r);
      int          count, sel;
      longint      h;
      density_type res;
      if (r.op == OP_WRITE) begin
         top_tbl[r.slot] = longint'(r.top);
         mass_tbl[r.slot] = 64'(r.mass);
         scale_tbl[r.slot] = 64'(r.scale);
      end else begin
         h = longint'(r.alt);
         count = (layer_count == 0) ? 1 : (layer_count > LAYERS ? LAYERS : layer_count);
         sel = count - 1;
         for (int i = 0; i < count; i++) begin
            if (h < top_tbl[i]) begin
               sel = i;
               break;
            end
         end
         res = calc_density(h, mass_tbl[sel], scale_tbl[sel]);
         res.layer_used = 4'(sel);
         density_exp = {density_exp, res};
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) apply_request(cur_req);
         if (!(start && busy)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
               cur_req = pending_reqs.pop_front();
               start           <= 1'b1;
               req_opcode      <= cur_req.op;
               req_layer_slot  <= cur_req.slot;
               req_layer_top   <= cur_req.top;
               req_layer_mass  <= cur_req.mass;
               req_layer_scale <= cur_req.scale;
               req_altitude    <= cur_req.alt;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (density_exp.size() == 0) begin
            $display("%0t: unexpected result density=%h sat=%b layer=%0d", $time,
                     rsp_density, rsp_saturated, rsp_layer_used);
            fails++;
         end else begin
            density_type want;
            want = density_exp.pop_front();
            if (want.density !== rsp_density) begin
               $display("%0t: density expected %h actual %h", $time, want.density,
                        rsp_density);
               fails++;
            end
            if (want.saturated !== rsp_saturated) begin
               $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                        rsp_saturated);
               fails++;
            end
            if (want.layer_used !== rsp_layer_used) begin
               $display("%0t: layer_used expected %0d actual %0d", $time,
                        want.layer_used, rsp_layer_used);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic request_type layer_write(input int slot, input int top, input int mass,
                                               input int scale);
      request_type r;
      r = '{op: OP_WRITE, slot: 4'(slot), top: 24'(top), mass: 27'(mass),
            scale: 21'(scale), alt: 24'd0};
      return r;
   endfunction

   function automatic request_type query(input int alt);
      request_type r;
      r = '{op: OP_QUERY, slot: 4'($urandom), top: 24'($urandom), mass: 27'($urandom),
            scale: 21'($urandom), alt: 24'(alt)};
      return r;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int          pick, slot;
      pick = $urandom_range(99);
      slot = $urandom_range(LAYERS - 1);
      if (pick < 15) begin
         r = '{op: op_type'($urandom_range(1)), slot: 4'($urandom), top: 24'($urandom),
               mass: 27'($urandom), scale: 21'($urandom), alt: 24'($urandom)};
      end else if (pick < 50) begin
         r = query($urandom_range(127 * 65536 + 65535) - 10 * 65536);
      end else begin
         r = layer_write(slot, slot * 8 * 65536 + $urandom_range(8 * 65536),
                         $urandom_range(27'h7FF_FFFF), $urandom_range(2000000, 100000));
      end
      return r;
   endfunction

   task automatic drain();
      wait (pending_reqs.size() == 0 && !start);
      wait (density_exp.size() == 0 && !busy);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_layer_count(input logic [4:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      layer_count = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [4:0] settings[6];
      settings = '{5'd16, 5'd0, 5'd31, 5'd5, 5'd16, 5'd2};
      fails = 0;
      quiet_cycles = 0;
      idle_pct = 38;
      layer_count = 5'd1;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_WRITE;
      req_layer_slot = '0;
      req_layer_top = '0;
      req_layer_mass = '0;
      req_layer_scale = '0;
      req_altitude = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < LAYERS; i++)
         queue_request(layer_write(i, i * 8 * 65536, 1000 * 65536, 700000));
      queue_request(query(-8388608));
      queue_request(query(8388607));
      queue_request(query(0));
      queue_request(layer_write(0, 8388607, 27'h7FF_FFFF, 0));
      queue_request(query(65536));
      queue_request(layer_write(0, -8388608, 0, 2097151));
      queue_request(query(-65536));
      queue_request(layer_write(0, 0, 1, 1));
      queue_request(query(-100));
      drain();

      for (int p = 0; p < 6; p++) begin
         idle_pct = (p < 2) ? 38 : (p < 4 ? 58 : 0);
         write_layer_count(settings[p]);
         for (int i = 0; i < 300; i++) queue_request(random_request());
         drain();
      end

      repeat (100) @(posedge clock);
      if (fails == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
